/* rtl/core/nmop_pkg.sv */
// Shared constants, stage payload type and the h(x) table for the normal-model pricer.
package nmop_pkg;

  localparam int CDF_SEGMENTS = 256;
  localparam int SEG_W        = $clog2(CDF_SEGMENTS);
  localparam int SUB_STEPS    = 8;
  localparam int SIMPSON_DIV  = 3 * CDF_SEGMENTS;

  localparam logic [63:0] ONE_Q32          = 64'h1_0000_0000;
  localparam logic [63:0] LN2_Q32          = 64'd2977044472;
  localparam logic [63:0] INV_SQRT_2PI_Q32 = 64'd1713444047;

  // stage map
  localparam int SQ_STAGES  = 28;
  localparam int ST_SD      = SQ_STAGES + 1;
  localparam int ST_CHK     = ST_SD + 1;
  localparam int DIV_BITS   = 31;
  localparam int ST_DIV0    = ST_CHK + 1;
  localparam int ST_DIVL    = ST_CHK + DIV_BITS;
  localparam int ST_SEG     = ST_DIVL + 1;
  localparam int ST_ROM     = ST_SEG + 1;
  localparam int ST_DH      = ST_ROM + 1;
  localparam int ST_T1      = ST_DH + 1;
  localparam int ST_TV      = ST_T1 + 1;
  localparam int ST_PRICE   = ST_TV + 1;
  localparam int NST        = ST_PRICE + 1;

  typedef logic [CDF_SEGMENTS:0][31:0] hrom_t;

  typedef struct packed {
    logic             err;
    logic [31:0]      ann;
    logic [31:0]      mpos;
    logic [32:0]      am;
    logic [31:0]      vol;
    logic [55:0]      rad;
    logic [56:0]      root;
    logic [47:0]      intr;
    logic [31:0]      sd;
    logic             tv_ok;
    logic [31:0]      rem;
    logic [30:0]      quo;
    logic [SEG_W-1:0] seg;
    logic [30:0]      frac;
    logic [31:0]      h0;
    logic [31:0]      h1;
    logic [31:0]      dh;
    logic [31:0]      t1;
    logic [47:0]      tv;
    logic [47:0]      price;
  } pipe_t;

  function automatic logic [63:0] exp_neg_q32(logic [63:0] y);
    logic [63:0] k;
    logic [63:0] r;
    logic [63:0] p;
    k = y / LN2_Q32;
    r = y - k * LN2_Q32;
    p = ONE_Q32;
    if (k >= 64'd63) begin
      return 64'd0;
    end
    for (int i = 14; i >= 1; i--) begin
      p = ONE_Q32 - (((r * p) >> 32) / 64'(i));
    end
    return p >> k;
  endfunction

  function automatic logic [63:0] grid_x_q28(logic [63:0] j);
    return (j << 28) / CDF_SEGMENTS;
  endfunction

  function automatic logic [63:0] density_q32(logic [63:0] j);
    logic [63:0] x;
    logic [63:0] y;
    x = grid_x_q28(j);
    y = (x * x) >> 25;
    return (exp_neg_q32(y) * INV_SQRT_2PI_Q32) >> 32;
  endfunction

  function automatic hrom_t build_hrom();
    hrom_t       h;
    logic [63:0] q;
    logic [63:0] sum;
    logic [63:0] w;
    logic [63:0] base;
    logic [63:0] n0;
    logic [63:0] xq;
    logic [63:0] hv;
    h = '0;
    q = 64'd0;
    for (int ii = CDF_SEGMENTS - 1; ii >= 0; ii--) begin
      base = 64'(ii * SUB_STEPS);
      sum  = 64'd0;
      for (int s = 0; s <= SUB_STEPS; s++) begin
        if (s == 0 || s == SUB_STEPS) begin
          w = 64'd1;
        end else if ((s & 1) == 1) begin
          w = 64'd4;
        end else begin
          w = 64'd2;
        end
        sum = sum + w * density_q32(base + 64'(s));
      end
      q  = q + sum / SIMPSON_DIV;
      n0 = density_q32(base);
      xq = (grid_x_q28(base) * q) >> 28;
      hv = (n0 > xq) ? n0 - xq : 64'd0;
      if (hv < 64'(h[ii+1])) begin
        hv = 64'(h[ii+1]);
      end
      h[ii] = hv[31:0];
    end
    return h;
  endfunction

  localparam hrom_t HROM = build_hrom();

endpackage

/* rtl/core/normal_model_option_pricer_unit.sv */
// Bachelier normal-model option pricer: one request per cycle through a 68-stage pipeline.
//
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------------
//  in      | in_valid / in_ready  | forward, strike, expiry, vol, annuity, is_payer
//  out     | out_valid / out_ready| option_price, input_error
//
// Takes one request per cycle unless a result held at the output stalls the pipeline.
// Latency comes from the 28-stage square-root array and the 31-stage divider.
// Synchronous active-low reset clears the stage valid bits only.
// A result held at the output with out_ready low freezes every stage, in_ready drops.
module normal_model_option_pricer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_forward_rate,
  input  logic [31:0] in_strike_rate,
  input  logic [31:0] in_expiry_years,
  input  logic [31:0] in_normal_vol,
  input  logic [31:0] in_annuity_factor,
  input  logic        in_is_payer,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [47:0] out_option_price,
  output logic        out_input_error
);
  import nmop_pkg::*;

  pipe_t       pipe_r [NST];
  pipe_t       pipe_nxt [NST];
  logic [NST-1:0] vld_r;
  logic        adv;

  assign adv      = !vld_r[NST-1] || out_ready;
  assign in_ready = adv;

  // entry
  always_comb begin
    logic signed [32:0] m;
    m = in_is_payer ? (33'(signed'(in_forward_rate)) - 33'(signed'(in_strike_rate)))
                    : (33'(signed'(in_strike_rate)) - 33'(signed'(in_forward_rate)));
    pipe_nxt[0]      = '0;
    pipe_nxt[0].err  = (in_expiry_years == 32'd0) || (in_annuity_factor == 32'd0);
    pipe_nxt[0].ann  = in_annuity_factor;
    pipe_nxt[0].vol  = in_normal_vol;
    pipe_nxt[0].am   = m[32] ? 33'(-m) : 33'(m);
    pipe_nxt[0].mpos = (!m[32] && m != 33'sd0) ? m[31:0] : 32'd0;
    pipe_nxt[0].rad  = {in_expiry_years, 24'd0};
    pipe_nxt[0].root = '0;
  end

  // square root, one result bit per stage
  for (genvar gi = 1; gi <= SQ_STAGES; gi++) begin : g_sqrt
    always_comb begin
      logic [56:0] b;
      logic [56:0] t;
      b = 57'd1 << (54 - 2 * (gi - 1));
      t = pipe_r[gi-1].root + b;
      pipe_nxt[gi] = pipe_r[gi-1];
      if ({1'b0, pipe_r[gi-1].rad} >= t) begin
        pipe_nxt[gi].rad  = 56'({1'b0, pipe_r[gi-1].rad} - t);
        pipe_nxt[gi].root = (pipe_r[gi-1].root >> 1) + b;
      end else begin
        pipe_nxt[gi].root = pipe_r[gi-1].root >> 1;
      end
    end
  end

  always_comb begin
    logic [63:0] sdp;
    logic [63:0] inp;
    sdp = 64'(pipe_r[ST_SD-1].vol) * 64'(pipe_r[ST_SD-1].root[28:0]);
    inp = 64'(pipe_r[ST_SD-1].ann) * 64'(pipe_r[ST_SD-1].mpos);
    pipe_nxt[ST_SD]      = pipe_r[ST_SD-1];
    pipe_nxt[ST_SD].sd   = sdp[59:28];
    pipe_nxt[ST_SD].intr = inp[63:16];
  end

  always_comb begin
    pipe_nxt[ST_CHK]       = pipe_r[ST_CHK-1];
    pipe_nxt[ST_CHK].tv_ok = (pipe_r[ST_CHK-1].sd != 32'd0) &&
                             ({3'd0, pipe_r[ST_CHK-1].am} < {1'b0, pipe_r[ST_CHK-1].sd, 3'd0});
    pipe_nxt[ST_CHK].rem   = 32'(pipe_r[ST_CHK-1].am >> 3);
    pipe_nxt[ST_CHK].quo   = '0;
  end

  // restoring divide of |m|*2^28 by sd, quotient bit 30 first
  for (genvar gj = 0; gj < DIV_BITS; gj++) begin : g_div
    localparam int K = DIV_BITS - 1 - gj;
    always_comb begin
      logic        nb;
      logic [32:0] t;
      nb = (K >= 28) ? pipe_r[ST_DIV0+gj-1].am[(K >= 28) ? K - 28 : 0] : 1'b0;
      t  = {pipe_r[ST_DIV0+gj-1].rem, nb};
      pipe_nxt[ST_DIV0+gj] = pipe_r[ST_DIV0+gj-1];
      if (t >= {1'b0, pipe_r[ST_DIV0+gj-1].sd}) begin
        pipe_nxt[ST_DIV0+gj].rem    = 32'(t - {1'b0, pipe_r[ST_DIV0+gj-1].sd});
        pipe_nxt[ST_DIV0+gj].quo[K] = 1'b1;
      end else begin
        pipe_nxt[ST_DIV0+gj].rem    = t[31:0];
      end
    end
  end

  always_comb begin
    logic [63:0] p;
    logic [63:0] segf;
    p    = 64'(pipe_r[ST_SEG-1].quo) * 64'(CDF_SEGMENTS);
    segf = p >> 31;
    pipe_nxt[ST_SEG]      = pipe_r[ST_SEG-1];
    pipe_nxt[ST_SEG].frac = p[30:0];
    if (segf >= 64'(CDF_SEGMENTS)) begin
      pipe_nxt[ST_SEG].seg = SEG_W'(CDF_SEGMENTS - 1);
    end else begin
      pipe_nxt[ST_SEG].seg = segf[SEG_W-1:0];
    end
  end

  always_comb begin
    logic [SEG_W:0] s0;
    s0 = {1'b0, pipe_r[ST_ROM-1].seg};
    pipe_nxt[ST_ROM]    = pipe_r[ST_ROM-1];
    pipe_nxt[ST_ROM].h0 = HROM[s0];
    pipe_nxt[ST_ROM].h1 = HROM[s0 + 1'b1];
  end

  always_comb begin
    logic [63:0] dp;
    dp = 64'(pipe_r[ST_DH-1].h0 - pipe_r[ST_DH-1].h1) * 64'(pipe_r[ST_DH-1].frac);
    pipe_nxt[ST_DH]    = pipe_r[ST_DH-1];
    pipe_nxt[ST_DH].dh = dp[62:31];
  end

  always_comb begin
    logic [31:0] hv;
    logic [63:0] tp;
    hv = pipe_r[ST_T1-1].h0 - pipe_r[ST_T1-1].dh;
    tp = 64'(pipe_r[ST_T1-1].sd) * 64'(hv);
    pipe_nxt[ST_T1]    = pipe_r[ST_T1-1];
    pipe_nxt[ST_T1].t1 = tp[63:32];
  end

  always_comb begin
    logic [63:0] vp;
    vp = 64'(pipe_r[ST_TV-1].ann) * 64'(pipe_r[ST_TV-1].t1);
    pipe_nxt[ST_TV]    = pipe_r[ST_TV-1];
    pipe_nxt[ST_TV].tv = pipe_r[ST_TV-1].tv_ok ? vp[63:16] : 48'd0;
  end

  always_comb begin
    logic [48:0] sum;
    sum = {1'b0, pipe_r[ST_PRICE-1].intr} + {1'b0, pipe_r[ST_PRICE-1].tv};
    pipe_nxt[ST_PRICE] = pipe_r[ST_PRICE-1];
    if (pipe_r[ST_PRICE-1].err) begin
      pipe_nxt[ST_PRICE].price = 48'd0;
    end else if (sum[48]) begin
      pipe_nxt[ST_PRICE].price = '1;
    end else begin
      pipe_nxt[ST_PRICE].price = sum[47:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  for (genvar gk = 0; gk < NST; gk++) begin : g_stage
    always_ff @(posedge clk) begin
      if (adv) begin
        pipe_r[gk] <= pipe_nxt[gk];
      end
    end
  end

  assign out_valid        = vld_r[NST-1];
  assign out_option_price = pipe_r[NST-1].price;
  assign out_input_error  = pipe_r[NST-1].err;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_input_error |-> out_option_price == 48'd0)
    else $error("error result with nonzero price");

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_option_price))
    else $error("held result lost");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[ST_DIVL] && pipe_r[ST_DIVL].tv_ok |-> pipe_r[ST_DIVL].rem < pipe_r[ST_DIVL].sd)
    else $error("divider remainder out of range");

  a_root: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[SQ_STAGES] |-> pipe_r[SQ_STAGES].root[56:28] == 29'd0)
    else $error("square root out of range");

endmodule
